[rtl/stbs_pkg.sv]
// Shared types and constants for the sorted-table binary search block.
// No dependencies; imported by stbs_search and sorted_table_binary_search_top.
package stbs_pkg;

  localparam int DATA_W = 32;  // table entry and key width
  localparam int IDX_W  = 10;  // entry_index / match_index width
  localparam int CNT_W  = 11;  // element_count width

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SEARCH = 1'b1
  } stbs_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_DONE
  } stbs_state_t;

  typedef struct packed {
    stbs_op_t                  opcode;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DATA_W-1:0]  data_value;
  } stbs_req_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } stbs_res_t;

endpackage

[rtl/stbs_search.sv]
// Table memory and probe sequencer: one synchronous read per probe, then compare.
// Depends on stbs_pkg.
module stbs_search import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] element_count,
  input  logic             req_valid,
  output logic             req_ready,
  input  stbs_req_t        req,
  output logic             res_valid,
  input  logic             res_ready,
  output stbs_res_t        res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];

  stbs_state_t              state_r, state_nxt;
  logic [CNT_W-1:0]         low_r, low_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;     // exclusive upper bound
  logic [CNT_W-1:0]         mid_r, mid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     found_r, found_nxt;
  logic signed [DATA_W-1:0] rd_data_r;

  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid_calc;
  logic [CNT_W-1:0] mid_inc;
  logic             mem_we;
  logic             mem_re;

  // midpoint of [low, hi-1]
  assign span     = hi_r - low_r - CNT_W'(1);
  assign mid_calc = low_r + (span >> 1);
  assign mid_inc  = mid_r + CNT_W'(1);

  assign mem_we = (state_r == ST_IDLE) && req_valid && (req.opcode == OP_WRITE) &&
                  (32'(req.entry_index) < TABLE_DEPTH);
  assign mem_re = (state_r == ST_PROBE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(req.entry_index)] <= req.data_value;
    end
    if (mem_re) begin
      rd_data_r <= mem[AW'(mid_calc)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    low_r   <= low_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid && (req.opcode == OP_SEARCH)) begin
          key_nxt   = req.data_value;
          low_nxt   = '0;
          hi_nxt    = element_count;
          mid_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = (element_count == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        mid_nxt   = mid_calc;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else if (rd_data_r < key_r) begin
          low_nxt   = mid_inc;
          state_nxt = (mid_inc >= hi_r) ? ST_DONE : ST_PROBE;
        end else begin
          hi_nxt    = mid_r;
          state_nxt = (low_r >= mid_r) ? ST_DONE : ST_PROBE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign res.found       = found_r;
  assign res.match_index = found_r ? mid_r[IDX_W-1:0] : '0;

endmodule

[rtl/sorted_table_binary_search_top.sv]
// Sorted-table binary search. Write request: taken while idle, no result.
// Search request: a read state and a compare state per probe, floor(log2(count))+1 probes
// at most (11 for 1024 entries); the result is registered in the search engine, then in
// the output register, and the next request is taken once the engine is idle again.
// Each probe is a registered read of the table memory followed by the compare.
// Reset clears control state and element_count; table contents stay undefined until written.
module sorted_table_binary_search_top import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_element_count,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_match_index
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  stbs_res_t        out_res_r;

  stbs_req_t req;
  stbs_res_t eng_res;
  logic      eng_res_valid;
  logic      eng_res_ready;

  assign req.opcode      = stbs_op_t'(in_opcode);
  assign req.entry_index = in_entry_index;
  assign req.data_value  = in_data_value;

  stbs_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk          (clk),
    .rst_n        (rst_n),
    .element_count(count_r),
    .req_valid    (in_valid),
    .req_ready    (in_ready),
    .req          (req),
    .res_valid    (eng_res_valid),
    .res_ready    (eng_res_ready),
    .res          (eng_res)
  );

  assign cfg_ready = 1'b1;

  // saturate the count at the table depth
  always_comb begin
    count_nxt = count_r;
    if (cfg_valid) begin
      if (32'(cfg_element_count) > TABLE_DEPTH) begin
        count_nxt = CNT_W'(TABLE_DEPTH);
      end else begin
        count_nxt = cfg_element_count;
      end
    end
  end

  // output register: refill as soon as the held result is taken
  assign eng_res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_res_valid && eng_res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (eng_res_valid && eng_res_ready) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_res_r.found;
  assign out_match_index = out_res_r.match_index;

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= TABLE_DEPTH)
    else $error("element count above table depth");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.found |-> out_res_r.match_index == '0)
    else $error("miss result with nonzero index");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    eng_res_valid && eng_res_ready |=> out_valid_r && out_res_r == $past(eng_res))
    else $error("search result not captured in output register");

endmodule

[dv/stbs_search_checker.sv]
// Scoreboard for the sorted-table binary search block: mirrors the table and the
// element count from observed requests, predicts each search result and compares.
// Depends on stbs_pkg for widths and the request/result types.
module stbs_search_checker import stbs_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CNT_W-1:0]         cfg_element_count,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_data_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_found,
  input  logic [IDX_W-1:0]         out_match_index,
  output int                       fail_count,
  output int                       pending,
  output int                       hit_count
);

  logic signed [DATA_W-1:0] entry_copy [TABLE_DEPTH];
  int                       search_span;
  stbs_res_t                expected_results [$];

  // Walk the same probe path as the block: midpoint, then narrow by signed order.
  function automatic stbs_res_t predict_search(logic signed [DATA_W-1:0] key);
    stbs_res_t res;
    int        lo;
    int        hi;
    int        mid;
    res.found       = 1'b0;
    res.match_index = '0;
    lo = 0;
    hi = search_span - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (entry_copy[mid] == key) begin
        res.found       = 1'b1;
        res.match_index = mid[IDX_W-1:0];
        return res;
      end else if (entry_copy[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return res;
  endfunction

  initial begin
    fail_count  = 0;
    pending     = 0;
    hit_count   = 0;
    search_span = 0;
  end

  always @(posedge clk) begin
    stbs_res_t want;
    if (!rst_n) begin
      search_span = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no search outstanding, found=%0b index=%0d",
                   $time, out_found, out_match_index);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch, expected %0b, got %0b",
                     $time, want.found, out_found);
            fail_count++;
          end
          if (out_match_index !== want.match_index) begin
            $display("%0t: match_index mismatch, expected %0d, got %0d",
                     $time, want.match_index, out_match_index);
            fail_count++;
          end
          if (want.found) hit_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        // saturate counts beyond the table depth
        search_span = (int'(cfg_element_count) > TABLE_DEPTH) ? TABLE_DEPTH
                                                              : int'(cfg_element_count);
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_WRITE) begin
          entry_copy[in_entry_index] = in_data_value;
        end else begin
          expected_results.push_back(predict_search(in_data_value));
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

[dv/sorted_table_binary_search_top_tb.sv]
// Top-level testbench for sorted_table_binary_search_top: drives write/search requests
// and element_count settings, varies stalls on both sides, and gives the verdict.
// Depends on stbs_pkg, the block under test and stbs_search_checker.
module sorted_table_binary_search_top_tb;
  import stbs_pkg::*;

  localparam int DEPTH         = 1024;
  localparam int ITEM_TARGET   = 1770;
  localparam int QUIET_LIMIT   = 3000;
  localparam int HOLD_CYCLES   = 240;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [DATA_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] KEY_MAX = 32'h7fff_ffff;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CNT_W-1:0]         cfg_element_count;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_opcode;
  logic [IDX_W-1:0]         in_entry_index;
  logic signed [DATA_W-1:0] in_data_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_found;
  logic [IDX_W-1:0]         out_match_index;

  int fail_count;
  int pending;
  int hit_count;

  logic [DATA_W-1:0] shadow [DEPTH];
  int eff_count;
  int items_sent;
  int n_writes;
  int n_searches;
  int n_settings;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int hold_done;
  int quiet;

  sorted_table_binary_search_top #(.TABLE_DEPTH(DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_element_count (cfg_element_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_data_value     (in_data_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_index   (out_match_index)
  );

  stbs_search_checker #(.TABLE_DEPTH(DEPTH)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_element_count (cfg_element_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_entry_index    (in_entry_index),
    .in_data_value     (in_data_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_found         (out_found),
    .out_match_index   (out_match_index),
    .fail_count        (fail_count),
    .pending           (pending),
    .hit_count         (hit_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(input stbs_op_t op, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] val);
    if (items_sent < 1150) begin
      tx_idle_pct = 14;
      rx_idle_pct = 58;
    end else if (items_sent < 1460) begin
      tx_idle_pct = 58;
      rx_idle_pct = 14;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= idx;
    in_data_value  <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (op == OP_WRITE) begin
      shadow[idx] = val;
      n_writes++;
    end else begin
      n_searches++;
    end
  endtask

  // Hold off new requests until every search has answered, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_count(input int v);
    wait_drained();
    cfg_valid         <= 1'b1;
    cfg_element_count <= v[CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
    eff_count = (v > DEPTH) ? DEPTH : v;
  endtask

  // Load entries 0..n-1: ascending (wide or dense spacing) or random noise.
  task automatic fill_prefix(input int n, input bit sorted);
    longint            cur;
    longint            step_max;
    logic [DATA_W-1:0] v;
    if ($urandom_range(1) == 1) begin
      cur      = -64'sd2147483648 + longint'($urandom_range(0, 1000));
      step_max = 64'd4294967295 / n;
    end else begin
      cur      = longint'($signed($urandom()));
      step_max = 3;
    end
    for (int i = 0; i < n; i++) begin
      if (i > 0) cur += longint'($urandom_range(0, 32'(step_max)));
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      v = sorted ? cur[DATA_W-1:0] : $urandom();
      send_req(OP_WRITE, i[IDX_W-1:0], v);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (eff_count > 0 && r < 50) return shadow[$urandom_range(eff_count - 1)];
    if (eff_count > 0 && r < 65) begin
      if ($urandom_range(1) == 1) return shadow[$urandom_range(eff_count - 1)] + 1;
      return shadow[$urandom_range(eff_count - 1)] - 1;
    end
    if (r < 75) return ($urandom_range(1) == 1) ? KEY_MAX : KEY_MIN;
    return $urandom();
  endfunction

  task automatic run_searches(input int n);
    for (int k = 0; k < n; k++) begin
      send_req(OP_SEARCH, IDX_W'($urandom_range(DEPTH - 1)), pick_key());
    end
  endtask

  initial begin
    int r;
    int n;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_element_count = '0;
    in_valid          = 1'b0;
    in_opcode         = OP_WRITE;
    in_entry_index    = '0;
    in_data_value     = '0;
    eff_count         = 0;
    items_sent        = 0;
    n_writes          = 0;
    n_searches        = 0;
    n_settings        = 0;
    tx_idle_pct       = 14;
    rx_idle_pct       = 58;
    hold_req          = 0;
    quiet             = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty range
    set_count(0);
    send_req(OP_SEARCH, '0, 32'h0);
    send_req(OP_SEARCH, '1, KEY_MIN);
    send_req(OP_WRITE, 10'd0, KEY_MIN);
    send_req(OP_WRITE, 10'd1, KEY_MAX);
    send_req(OP_WRITE, 10'd1023, 32'h5a5a_a5a5);
    set_count(1);
    send_req(OP_SEARCH, '1, KEY_MIN);
    send_req(OP_SEARCH, '0, KEY_MAX);
    send_req(OP_SEARCH, '1, 32'h0);
    set_count(2);
    send_req(OP_SEARCH, '0, KEY_MAX);
    send_req(OP_SEARCH, '1, KEY_MIN);
    send_req(OP_SEARCH, '0, 32'hffff_ffff);
    // unsorted tail with a duplicate
    send_req(OP_WRITE, 10'd2, 32'd5);
    send_req(OP_WRITE, 10'd3, 32'd5);
    send_req(OP_WRITE, 10'd4, 32'd100);
    set_count(5);
    send_req(OP_SEARCH, '1, 32'd5);
    send_req(OP_SEARCH, '0, 32'd100);
    send_req(OP_SEARCH, '1, KEY_MAX);
    send_req(OP_SEARCH, '0, KEY_MIN);

    // full table, then full-depth and saturated counts under a long receiver hold
    fill_prefix(DEPTH, 1'b1);
    set_count(DEPTH);
    hold_req++;
    run_searches(30);
    set_count(2047);
    run_searches(20);

    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 10) begin
        set_count($urandom_range(DEPTH, 2047));
      end else if (r < 18) begin
        set_count(0);
      end else begin
        n = $urandom_range(1, 48);
        fill_prefix(n, $urandom_range(99) >= 15);
        set_count(n);
      end
      run_searches($urandom_range(8, 30));
    end

    wait_drained();
    $display("Ran %0d writes and %0d searches (%0d hits) across %0d element_count settings,",
             n_writes, n_searches, hit_count, n_settings);
    $display("including empty, full-depth and saturated tables, unsorted data and stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/stbs_pkg.sv
rtl/stbs_search.sv
rtl/sorted_table_binary_search_top.sv
dv/stbs_search_checker.sv
dv/sorted_table_binary_search_top_tb.sv
